// ===== rtl/core/lbp_pkg.sv =====
// Shared types, constants and tables for the laser beam to pixel rasteriser.
`timescale 1ns / 1ps
package lbp_pkg;

  // Rotation CORDIC: 16 micro-rotations, two per pipeline stage
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_ITERS  = 2;
  localparam int CORDIC_PIPE   = CORDIC_STAGES / CORDIC_ITERS;
  localparam int XW            = 34;   // Q2.30 plus headroom
  localparam int ZW            = 26;   // 2^24 per turn plus sign and headroom
  localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

  // Pipelined restoring divider, four quotient bits per stage
  localparam int DVS_W    = 16;
  localparam int QUO_W    = 28;
  localparam int DVD_W    = DVS_W + QUO_W;
  localparam int DIV_STEP = 4;
  localparam int DIV_PIPE = QUO_W / DIV_STEP;

  // Register map
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_MIN_RANGE    = 3'd0;
  localparam reg_idx_t REG_MAX_RANGE    = 3'd1;
  localparam reg_idx_t REG_ANGLE_START  = 3'd2;
  localparam reg_idx_t REG_ANGLE_STEP   = 3'd3;
  localparam reg_idx_t REG_IMAGE_WIDTH  = 3'd4;
  localparam reg_idx_t REG_IMAGE_HEIGHT = 3'd5;

  // Sideband carried through the CORDIC
  typedef struct packed {
    logic        valid;
    logic        acc;
    logic [15:0] range;
    logic [1:0]  quad;
  } side_t;

  // Sideband carried through the divider
  typedef struct packed {
    logic valid;
    logic acc;
    logic xneg;
    logic yneg;
  } div_tag_t;

  // atan(2^-i) in 2^24-per-turn units
  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 26'sd2097152;
      5'd1:    v = 26'sd1238021;
      5'd2:    v = 26'sd654136;
      5'd3:    v = 26'sd332050;
      5'd4:    v = 26'sd166669;
      5'd5:    v = 26'sd83416;
      5'd6:    v = 26'sd41718;
      5'd7:    v = 26'sd20860;
      5'd8:    v = 26'sd10430;
      5'd9:    v = 26'sd5215;
      5'd10:   v = 26'sd2608;
      5'd11:   v = 26'sd1304;
      5'd12:   v = 26'sd652;
      5'd13:   v = 26'sd326;
      5'd14:   v = 26'sd163;
      5'd15:   v = 26'sd81;
      5'd16:   v = 26'sd41;
      5'd17:   v = 26'sd20;
      5'd18:   v = 26'sd10;
      5'd19:   v = 26'sd5;
      5'd20:   v = 26'sd3;
      5'd21:   v = 26'sd1;
      5'd22:   v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/lbp_cordic.sv =====
// Pipelined rotation CORDIC giving cosine and sine of the residual angle.
`timescale 1ns / 1ps
module lbp_cordic (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ce,
  input  lbp_pkg::side_t                  in_side,
  input  logic signed [lbp_pkg::ZW-1:0]   in_z,
  output lbp_pkg::side_t                  out_side,
  output logic signed [lbp_pkg::XW-1:0]   out_x,
  output logic signed [lbp_pkg::XW-1:0]   out_y
);
  import lbp_pkg::*;

  side_t                side_r [CORDIC_PIPE];
  logic signed [XW-1:0] x_r    [CORDIC_PIPE];
  logic signed [XW-1:0] y_r    [CORDIC_PIPE];
  logic signed [ZW-1:0] z_r    [CORDIC_PIPE];

  for (genvar s = 0; s < CORDIC_PIPE; s++) begin : g_stage
    side_t                si;
    logic signed [XW-1:0] xi, yi, x_nxt, y_nxt, dx, dy;
    logic signed [ZW-1:0] zi, z_nxt;

    if (s == 0) begin : g_first
      assign si = in_side;
      assign xi = CORDIC_X0;
      assign yi = '0;
      assign zi = in_z;
    end else begin : g_next
      assign si = side_r[s-1];
      assign xi = x_r[s-1];
      assign yi = y_r[s-1];
      assign zi = z_r[s-1];
    end

    always_comb begin
      x_nxt = xi;
      y_nxt = yi;
      z_nxt = zi;
      dx    = '0;
      dy    = '0;
      for (int k = 0; k < CORDIC_ITERS; k++) begin
        dx = x_nxt;
        dy = y_nxt;
        dx = dy >>> (s * CORDIC_ITERS + k);
        dy = x_nxt >>> (s * CORDIC_ITERS + k);
        if (!z_nxt[ZW-1]) begin
          x_nxt = x_nxt - dx;
          y_nxt = y_nxt + dy;
          z_nxt = z_nxt - atan_val(5'(s * CORDIC_ITERS + k));
        end else begin
          x_nxt = x_nxt + dx;
          y_nxt = y_nxt - dy;
          z_nxt = z_nxt + atan_val(5'(s * CORDIC_ITERS + k));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s].valid <= 1'b0;
      end else if (ce) begin
        side_r[s] <= si;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        x_r[s] <= x_nxt;
        y_r[s] <= y_nxt;
        z_r[s] <= z_nxt;
      end
    end
  end

  assign out_side = side_r[CORDIC_PIPE-1];
  assign out_x    = x_r[CORDIC_PIPE-1];
  assign out_y    = y_r[CORDIC_PIPE-1];

endmodule

// ===== rtl/core/lbp_div.sv =====
// Two-lane pipelined restoring divider sharing one divisor.
`timescale 1ns / 1ps
module lbp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  lbp_pkg::div_tag_t             in_tag,
  input  logic [lbp_pkg::DVD_W-1:0]     in_dvd_x,
  input  logic [lbp_pkg::DVD_W-1:0]     in_dvd_y,
  input  logic [lbp_pkg::DVS_W-1:0]     divisor,
  output lbp_pkg::div_tag_t             out_tag,
  output logic [lbp_pkg::QUO_W-1:0]     out_qx,
  output logic [lbp_pkg::QUO_W-1:0]     out_qy
);
  import lbp_pkg::*;

  div_tag_t         tag_r [DIV_PIPE];
  logic [DVS_W-1:0] rem_r [DIV_PIPE][2];
  logic [QUO_W-1:0] dq_r  [DIV_PIPE][2];

  for (genvar s = 0; s < DIV_PIPE; s++) begin : g_stage
    div_tag_t         ti;
    logic [DVS_W-1:0] rem_i [2];
    logic [QUO_W-1:0] dq_i  [2];
    logic [DVS_W-1:0] rem_nxt [2];
    logic [QUO_W-1:0] dq_nxt  [2];

    if (s == 0) begin : g_first
      assign ti       = in_tag;
      assign rem_i[0] = in_dvd_x[DVD_W-1:QUO_W];
      assign dq_i[0]  = in_dvd_x[QUO_W-1:0];
      assign rem_i[1] = in_dvd_y[DVD_W-1:QUO_W];
      assign dq_i[1]  = in_dvd_y[QUO_W-1:0];
    end else begin : g_next
      assign ti       = tag_r[s-1];
      assign rem_i[0] = rem_r[s-1][0];
      assign dq_i[0]  = dq_r[s-1][0];
      assign rem_i[1] = rem_r[s-1][1];
      assign dq_i[1]  = dq_r[s-1][1];
    end

    always_comb begin
      logic [DVS_W:0] t;
      logic           ge;
      for (int l = 0; l < 2; l++) begin
        rem_nxt[l] = rem_i[l];
        dq_nxt[l]  = dq_i[l];
        for (int k = 0; k < DIV_STEP; k++) begin
          // shift in the next dividend bit, subtract where it fits
          t          = {rem_nxt[l], dq_nxt[l][QUO_W-1]};
          ge         = (t >= {1'b0, divisor});
          dq_nxt[l]  = {dq_nxt[l][QUO_W-2:0], ge};
          rem_nxt[l] = ge ? DVS_W'(t - {1'b0, divisor}) : t[DVS_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s].valid <= 1'b0;
      end else if (ce) begin
        tag_r[s] <= ti;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[s][0] <= rem_nxt[0];
        rem_r[s][1] <= rem_nxt[1];
        dq_r[s][0]  <= dq_nxt[0];
        dq_r[s][1]  <= dq_nxt[1];
      end
    end
  end

  assign out_tag = tag_r[DIV_PIPE-1];
  assign out_qx  = dq_r[DIV_PIPE-1][0];
  assign out_qy  = dq_r[DIV_PIPE-1][1];

endmodule

// ===== rtl/core/laser_beam_to_pixel_top.sv =====
// Top level of the laser beam to pixel rasteriser: ports, registers and pipeline glue.
//
//   Channel  Ports       Direction  Contents
//   input    in_*        in         tdata: range_mm[15:0], beam_index[27:16]
//   result   out_*       out        tdata: pixel_x[9:0], pixel_y[19:10]; tuser: hit
//   config   cfg_*       in/out     APB-style, six registers at 4*i
//
// One request enters per cycle unless the pipeline holds; the path runs through the eight CORDIC
// stages and seven divider stages (four quotient bits each).
// rst_n is synchronous; it clears the valid bits and loads register defaults.
// When the result is not taken the whole pipeline holds; nothing is dropped.
`timescale 1ns / 1ps
module laser_beam_to_pixel_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // range_mm[15:0], beam_index[27:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_x[9:0], pixel_y[19:10]
  output logic        out_tuser,  // hit[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lbp_pkg::*;

  localparam logic signed [XW-1:0] Q_MAX  = 34'sd32767;
  localparam logic signed [XW-1:0] Q_MIN  = -34'sd32767;
  localparam logic signed [XW-1:0] Q_HALF = 34'sd16384;

  // Configuration registers
  logic [15:0] min_range_r, max_range_r, angle_start_r;
  logic [11:0] angle_step_r;
  logic [9:0]  image_width_r, image_height_r;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r    <= 16'd0;
      max_range_r    <= 16'd3500;
      angle_start_r  <= 16'd0;
      angle_step_r   <= 12'd182;
      image_width_r  <= 10'd228;
      image_height_r <= 10'd210;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_idx)
        REG_MIN_RANGE:    min_range_r    <= cfg_pwdata[15:0];
        REG_MAX_RANGE:    max_range_r    <= cfg_pwdata[15:0];
        REG_ANGLE_START:  angle_start_r  <= cfg_pwdata[15:0];
        REG_ANGLE_STEP:   angle_step_r   <= cfg_pwdata[11:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_pwdata[9:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_RANGE:    cfg_prdata = {16'd0, min_range_r};
      REG_MAX_RANGE:    cfg_prdata = {16'd0, max_range_r};
      REG_ANGLE_START:  cfg_prdata = {{16{angle_start_r[15]}}, angle_start_r};
      REG_ANGLE_STEP:   cfg_prdata = {20'd0, angle_step_r};
      REG_IMAGE_WIDTH:  cfg_prdata = {22'd0, image_width_r};
      REG_IMAGE_HEIGHT: cfg_prdata = {22'd0, image_height_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // Pipeline advance: hold everything while the result waits
  logic out_valid_r;
  logic ce;
  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  // Stage 0: input capture
  logic        s0_valid_r;
  logic [15:0] s0_range_r;
  logic [11:0] s0_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (ce) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_range_r <= in_tdata[15:0];
      s0_idx_r   <= in_tdata[27:16];
    end
  end

  // Stage 1: range check and beam angle
  logic [23:0] ang_prod;
  logic [15:0] ang;
  side_t       s1_side_r;
  logic [13:0] s1_res_r;

  assign ang_prod = s0_idx_r * angle_step_r;
  assign ang      = angle_start_r + ang_prod[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.valid <= 1'b0;
    end else if (ce) begin
      s1_side_r.valid <= s0_valid_r;
      s1_side_r.acc   <= (max_range_r != 16'd0) && (s0_range_r >= min_range_r)
                         && (s0_range_r <= max_range_r);
      s1_side_r.range <= s0_range_r;
      s1_side_r.quad  <= ang[15:14];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_res_r <= ang[13:0];
    end
  end

  // CORDIC
  side_t                cd_side;
  logic signed [XW-1:0] cd_x, cd_y;

  lbp_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_side  (s1_side_r),
    .in_z     ($signed({4'd0, s1_res_r, 8'd0})),
    .out_side (cd_side),
    .out_x    (cd_x),
    .out_y    (cd_y)
  );

  // Stage Q: round to Q1.15 and rotate by quadrant
  function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + Q_HALF) >>> 15;
    if (r > Q_MAX) r = Q_MAX;
    if (r < Q_MIN) r = Q_MIN;
    return r[15:0];
  endfunction

  logic signed [15:0] cq, sq, cos_v, sin_v;
  side_t              sq_side_r;
  logic signed [15:0] sq_cos_r, sq_sin_r;

  assign cq = to_q15(cd_x);
  assign sq = to_q15(cd_y);

  always_comb begin
    case (cd_side.quad)
      2'd0:    begin cos_v = cq;  sin_v = sq;  end
      2'd1:    begin cos_v = -sq; sin_v = cq;  end
      2'd2:    begin cos_v = -cq; sin_v = -sq; end
      default: begin cos_v = sq;  sin_v = -cq; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_side_r.valid <= 1'b0;
    end else if (ce) begin
      sq_side_r <= cd_side;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_cos_r <= cos_v;
      sq_sin_r <= sin_v;
    end
  end

  // Stage M1: range times trig magnitude
  logic [15:0] cos_abs, sin_abs;
  div_tag_t    m1_tag_r;
  logic [30:0] m1_px_r, m1_py_r;

  assign cos_abs = sq_cos_r[15] ? 16'(-sq_cos_r) : sq_cos_r;
  assign sin_abs = sq_sin_r[15] ? 16'(-sq_sin_r) : sq_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_tag_r.valid <= 1'b0;
    end else if (ce) begin
      m1_tag_r.valid <= sq_side_r.valid;
      m1_tag_r.acc   <= sq_side_r.acc;
      m1_tag_r.xneg  <= sq_cos_r[15];
      m1_tag_r.yneg  <= sq_sin_r[15];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m1_px_r <= sq_side_r.range * cos_abs[14:0];
      m1_py_r <= sq_side_r.range * sin_abs[14:0];
    end
  end

  // Stage M2: times image size
  div_tag_t         m2_tag_r;
  logic [DVD_W-1:0] m2_dx_r, m2_dy_r;
  logic [40:0]      prod_x, prod_y;

  assign prod_x = m1_px_r * image_width_r;
  assign prod_y = m1_py_r * image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_tag_r.valid <= 1'b0;
    end else if (ce) begin
      m2_tag_r <= m1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m2_dx_r <= DVD_W'(prod_x);
      m2_dy_r <= DVD_W'(prod_y);
    end
  end

  // Divide by max range
  div_tag_t         dv_tag;
  logic [QUO_W-1:0] dv_qx, dv_qy;

  lbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_tag   (m2_tag_r),
    .in_dvd_x (m2_dx_r),
    .in_dvd_y (m2_dy_r),
    .divisor  (max_range_r),
    .out_tag  (dv_tag),
    .out_qx   (dv_qx),
    .out_qy   (dv_qy)
  );

  // Final stage: offset by image centre, truncate, bounds check
  logic signed [29:0] off_x, off_y, pos_x, pos_y;
  logic [9:0]         px, py;
  logic               x_zero, y_zero, x_in, y_in;
  logic               hit;
  logic [9:0]         out_px_r, out_py_r;
  logic               out_hit_r;

  assign off_x = dv_tag.xneg ? -$signed({2'b00, dv_qx}) : $signed({2'b00, dv_qx});
  assign off_y = dv_tag.yneg ? -$signed({2'b00, dv_qy}) : $signed({2'b00, dv_qy});
  assign pos_x = off_x + $signed({5'd0, image_width_r, 15'd0});
  assign pos_y = off_y + $signed({5'd0, image_height_r, 15'd0});
  // a position just below zero truncates towards zero onto pixel 0
  assign x_zero = pos_x[29] && (&pos_x[28:16]) && (|pos_x[15:0]);
  assign y_zero = pos_y[29] && (&pos_y[28:16]) && (|pos_y[15:0]);
  assign px    = x_zero ? 10'd0 : pos_x[25:16];
  assign py    = y_zero ? 10'd0 : pos_y[25:16];
  assign x_in  = x_zero || (!pos_x[29] && (pos_x[28:26] == 3'd0));
  assign y_in  = y_zero || (!pos_y[29] && (pos_y[28:26] == 3'd0));
  assign hit   = dv_tag.acc && x_in && y_in && (px < image_width_r)
                 && (py < image_height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= dv_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_px_r  <= hit ? px : 10'd0;
      out_py_r  <= hit ? py : 10'd0;
      out_hit_r <= hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_py_r, out_px_r};
  assign out_tuser  = out_hit_r;

endmodule
